FILE: src/llcgs_pkg.sv
// Shared types and constants for the life-like cell grid stepper.
`timescale 1ns / 1ps

package llcgs_pkg;

   localparam int AREA_LIMIT = 16;
   localparam int POS_W      = 4;
   localparam int AREA_W     = 5;
   localparam int MASK_W     = 9;
   localparam int POP_W      = 9;

   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_ADVANCE = 2'd1,
      CMD_READ    = 2'd2,
      CMD_NONE    = 2'd3
   } llcgs_cmd_type;

   typedef enum logic [1:0] {
      REG_COLS    = 2'd0,
      REG_ROWS    = 2'd1,
      REG_BIRTH   = 2'd2,
      REG_SURVIVE = 2'd3
   } llcgs_reg_type;

   typedef struct packed {
      logic              wr_en;
      logic              adv_en;
      logic              rd_en;
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic              val;
      logic [AREA_W-1:0] w;
      logic [AREA_W-1:0] h;
      logic [MASK_W-1:0] birth;
      logic [MASK_W-1:0] survive;
   } llcgs_ctl_type;

   typedef struct packed {
      logic [POP_W-1:0] count;
      logic             bit_val;
   } llcgs_scan_type;

endpackage

FILE: src/life_like_cell_grid_stepper.sv
// Top level: command handshake, rule registers, and the chain of grid rows.
// A new command is taken only in the idle state, once the previous sweep has loaded its
//   result into the output register; the population and read scan steps one row per
//   cycle down the row chain.
// Reset: all cells dead, 16 x 16 area, birth mask 8 and survive mask 12 (B3/S23).
// A pending result may wait in the output register while the next beat is taken.
`timescale 1ns / 1ps

module life_like_cell_grid_stepper
   import llcgs_pkg::*;
#(
   parameter int GRID_WIDTH  = 16,
   parameter int GRID_HEIGHT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // x_pos[3:0], y_pos[7:4], cell_in[8], zero pad
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // cell_out[0], in_area[1], live_count[10:2], zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_SWEEP = 2'b10
   } state_type;

   localparam int CNT_W = $clog2(GRID_HEIGHT + 1);
   localparam logic [AREA_W-1:0] MAX_W =
      AREA_W'((GRID_WIDTH < AREA_LIMIT) ? GRID_WIDTH : AREA_LIMIT);
   localparam logic [AREA_W-1:0] MAX_H =
      AREA_W'((GRID_HEIGHT < AREA_LIMIT) ? GRID_HEIGHT : AREA_LIMIT);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [AREA_W-1:0] cols_ff, rows_ff;
   logic [MASK_W-1:0] birth_ff, survive_ff;
   logic [AREA_W-1:0] used_w, used_h;
   llcgs_cmd_type     req_cmd;
   logic [POS_W-1:0]  req_x, req_y;
   logic              req_val, accept, addr_in_area, in_area_now;
   llcgs_cmd_type     cmd_ff;
   logic [POS_W-1:0]  x_ff, y_ff;
   logic              in_area_ff;
   logic              rsp_tvalid_ff, rsp_load;
   logic              rsp_cell_ff, rsp_area_ff;
   logic [POP_W-1:0]  rsp_live_ff;
   llcgs_ctl_type     ctl;
   logic [GRID_WIDTH-1:0] grid_rows [GRID_HEIGHT];
   llcgs_scan_type        scan_chain [GRID_HEIGHT+1];

   assign req_cmd = llcgs_cmd_type'(req_tuser);
   assign req_x   = req_tdata[3:0];
   assign req_y   = req_tdata[7:4];
   assign req_val = req_tdata[8];

   assign used_w = (cols_ff > MAX_W) ? MAX_W : cols_ff;
   assign used_h = (rows_ff > MAX_H) ? MAX_H : rows_ff;

   assign req_tready   = state_ff == ST_IDLE;
   assign accept       = req_tvalid && req_tready;
   assign addr_in_area = (AREA_W'(req_x) < used_w) && (AREA_W'(req_y) < used_h);
   assign in_area_now  = addr_in_area && (req_cmd != CMD_NONE);
   assign csr_ready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff    <= AREA_W'(16);
         rows_ff    <= AREA_W'(16);
         birth_ff   <= MASK_W'(8);
         survive_ff <= MASK_W'(12);
      end else if (csr_valid && csr_ready) begin
         unique case (llcgs_reg_type'(csr_index))
            REG_COLS:    cols_ff    <= csr_data[AREA_W-1:0];
            REG_ROWS:    rows_ff    <= csr_data[AREA_W-1:0];
            REG_BIRTH:   birth_ff   <= csr_data;
            REG_SURVIVE: survive_ff <= csr_data;
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= req_cmd;
         x_ff       <= req_x;
         y_ff       <= req_y;
         in_area_ff <= in_area_now;
      end
   end

   always_comb begin
      ctl.wr_en   = accept && (req_cmd == CMD_WRITE) && addr_in_area;
      ctl.adv_en  = accept && (req_cmd == CMD_ADVANCE);
      ctl.rd_en   = (cmd_ff == CMD_READ) && in_area_ff;
      ctl.x       = accept ? req_x : x_ff;
      ctl.y       = accept ? req_y : y_ff;
      ctl.val     = req_val;
      ctl.w       = used_w;
      ctl.h       = used_h;
      ctl.birth   = birth_ff;
      ctl.survive = survive_ff;
   end

   assign scan_chain[0] = '0;

   for (genvar r = 0; r < GRID_HEIGHT; r++) begin : g_row
      logic [GRID_WIDTH-1:0] up_row, dn_row;
      if (r == 0) begin : g_top
         assign up_row = '0;
      end else begin : g_mid_up
         assign up_row = grid_rows[r-1];
      end
      if (r == GRID_HEIGHT - 1) begin : g_bot
         assign dn_row = '0;
      end else begin : g_mid_dn
         assign dn_row = grid_rows[r+1];
      end
      llcgs_row #(
         .GRID_WIDTH (GRID_WIDTH),
         .ROW        (r)
      ) u_row (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .up_row   (up_row),
         .dn_row   (dn_row),
         .row_out  (grid_rows[r]),
         .scan_in  (scan_chain[r]),
         .scan_out (scan_chain[r+1])
      );
   end

   assign rsp_load = (state_ff == ST_SWEEP) && (cnt_ff == '0)
                     && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SWEEP;
               cnt_in   = CNT_W'(GRID_HEIGHT);
            end
         end
         ST_SWEEP: begin
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - 1'b1;
            end else if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_cell_ff <= scan_chain[GRID_HEIGHT].bit_val;
         rsp_area_ff <= in_area_ff;
         rsp_live_ff <= scan_chain[GRID_HEIGHT].count;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'b0, rsp_live_ff, rsp_area_ff, rsp_cell_ff};

   a_rsp_from_sweep: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_SWEEP && cnt_ff == '0))
      else $error("result raised outside end of sweep");

   a_idle_cnt_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> cnt_ff == '0)
      else $error("scan counter running while idle");

   a_read_in_area: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_cell_ff |-> rsp_area_ff)
      else $error("read bit set outside area");

   a_pop_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> ({1'b0, rsp_live_ff} <= (10'(used_w) * 10'(used_h))))
      else $error("population exceeds area");

endmodule

FILE: src/llcgs_row.sv
// One grid row: holds its cells, applies the rule, and passes the population/read scan down.
`timescale 1ns / 1ps

module llcgs_row
   import llcgs_pkg::*;
#(
   parameter int GRID_WIDTH = 16,
   parameter int ROW        = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  llcgs_ctl_type         ctl,
   input  logic [GRID_WIDTH-1:0] up_row,
   input  logic [GRID_WIDTH-1:0] dn_row,
   output logic [GRID_WIDTH-1:0] row_out,
   input  llcgs_scan_type        scan_in,
   output llcgs_scan_type        scan_out
);

   logic [GRID_WIDTH-1:0] row_ff, row_in;
   logic [GRID_WIDTH-1:0] col_mask;
   logic [GRID_WIDTH-1:0] up_m, mid_m, dn_m;
   logic [GRID_WIDTH+1:0] up_p, mid_p, dn_p;
   logic [3:0]            nbr_cnt [GRID_WIDTH];
   logic                  row_live, dn_live, y_hit;
   logic [AREA_LIMIT-1:0] area_row;
   logic [3:0]            pc_lo, pc_hi;
   logic [4:0]            pc;
   llcgs_scan_type        scan_ff, scan_in_nx;

   assign row_live = ROW < int'(ctl.h);
   assign dn_live  = (ROW + 1) < int'(ctl.h);
   assign y_hit    = int'(ctl.y) == ROW;

   always_comb begin
      for (int c = 0; c < GRID_WIDTH; c++) begin
         col_mask[c] = c < int'(ctl.w);
      end
   end

   assign mid_m = row_ff & col_mask;
   assign up_m  = up_row & col_mask;
   assign dn_m  = dn_row & col_mask & {GRID_WIDTH{dn_live}};
   assign up_p  = {1'b0, up_m, 1'b0};
   assign mid_p = {1'b0, mid_m, 1'b0};
   assign dn_p  = {1'b0, dn_m, 1'b0};

   always_comb begin
      for (int c = 0; c < GRID_WIDTH; c++) begin
         nbr_cnt[c] = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
                    + 4'(mid_p[c]) + 4'(mid_p[c+2])
                    + 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
      end
   end

   always_comb begin
      for (int c = 0; c < GRID_WIDTH; c++) begin
         priority if (ctl.wr_en && y_hit && (int'(ctl.x) == c)) begin
            row_in[c] = ctl.val;
         end else if (ctl.adv_en && row_live && col_mask[c]) begin
            row_in[c] = row_ff[c] ? ctl.survive[nbr_cnt[c]] : ctl.birth[nbr_cnt[c]];
         end else begin
            row_in[c] = row_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_out = row_ff;

   for (genvar j = 0; j < AREA_LIMIT; j++) begin : g_area
      if (j < GRID_WIDTH) begin : g_on
         assign area_row[j] = mid_m[j] & row_live;
      end else begin : g_off
         assign area_row[j] = 1'b0;
      end
   end

   always_comb begin
      pc_lo = '0;
      pc_hi = '0;
      for (int j = 0; j < AREA_LIMIT / 2; j++) begin
         pc_lo = pc_lo + 4'(area_row[j]);
         pc_hi = pc_hi + 4'(area_row[j + AREA_LIMIT / 2]);
      end
      pc = 5'(pc_lo) + 5'(pc_hi);
   end

   always_comb begin
      scan_in_nx.count   = scan_in.count + POP_W'(pc);
      scan_in_nx.bit_val = scan_in.bit_val | (ctl.rd_en & y_hit & area_row[ctl.x]);
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in_nx;
   end

   assign scan_out = scan_ff;

endmodule
